// File: hdl/pma_pkg.sv
// Shared constants, types and codes for the pen moving average unit.
package pma_pkg;

    localparam int MAX_WINDOW   = 20;
    localparam int WINDOW_LOW   = 2;
    localparam int WINDOW_HIGH  = (20 < MAX_WINDOW) ? 20 : MAX_WINDOW;
    localparam int WINDOW_RESET = 5;
    localparam int WIN_W        = 5;

    localparam int POS_W  = 32;
    localparam int PRES_W = 16;
    localparam int DATA_W = 2 * POS_W + PRES_W;
    localparam int X_LSB  = 0;
    localparam int Y_LSB  = POS_W;
    localparam int P_LSB  = 2 * POS_W;

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = POS_W + $clog2(MAX_WINDOW);
    localparam int PSUM_W = PRES_W + $clog2(MAX_WINDOW);

    // Divider: DIV_STEP quotient bits per cycle
    localparam int DIV_STEP   = 8;
    localparam int DIV_CYCLES = (SUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_CYCLES * DIV_STEP;
    localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [1:0] OP_PROCESS = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_SEED    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

// File: hdl/pma_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
module pma_ram #(
    parameter int DEPTH = 20,
    parameter int WIDTH = 80
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/pma_div.sv
// Iterative divider of a channel sum by the sample count, truncating toward zero.
module pma_div
    import pma_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             is_signed,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     q_reg, q_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     d_reg, d_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [DIV_W-1:0]     step_q;
    logic [CNT_W-1:0]     step_r;
    logic [SUM_W-1:0]     mag;
    logic                 neg_in;

    assign neg_in = is_signed & dividend[SUM_W-1];
    assign mag    = neg_in ? (~dividend + 1'b1) : dividend;

    // restoring division, DIV_STEP bits per cycle
    always_comb
    begin : div_step
        logic [CNT_W:0]   t;
        logic [CNT_W-1:0] r;
        logic [DIV_W-1:0] q;
        r = rem_reg;
        q = q_reg;
        for (int j = 0; j < DIV_STEP; j++)
        begin
            t = {r, q[DIV_W-1]};
            q = {q[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, d_reg})
            begin
                r    = CNT_W'(t - {1'b0, d_reg});
                q[0] = 1'b1;
            end
            else
            begin
                r = t[CNT_W-1:0];
            end
        end
        step_q = q;
        step_r = r;
    end

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            q_next    = DIV_W'(mag);
            rem_next  = '0;
            d_next    = divisor;
            neg_next  = neg_in;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            q_next   = step_q;
            rem_next = step_r;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~q_reg + DIV_W'(1)) : q_reg;

`ifndef SYNTHESIS
    a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && done_reg))
        else $error("divider busy and done together");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(busy_reg))
        else $error("divider done without running");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= DIV_CNT_W'(DIV_CYCLES - 1))
        else $error("divider step count out of range");
`endif

endmodule

// File: hdl/pen_moving_average_unit.sv
// Top level of the pen moving average unit: history sequencer, sums and output register.
//
// Usage
//   s_* stream: one pen sample per transaction. s_tuser[1:0] is the operation
//   (0 process, 1 clear history, 2 clear and seed with this sample);
//   s_tdata holds x, y and pressure. m_* stream: one averaged sample per
//   process transaction. cfg_*: write of the window register (clamped to
//   2..20); cfg_ready is always high, writes belong in idle periods.
//   The history sits in a 20-entry RAM with registered read data. A process
//   transaction writes its sample, then reads back the newest n entries one
//   per cycle (n = stored count after the item), then three dividers run in
//   parallel at 8 quotient bits a cycle. The next sample is taken as soon as
//   the result is in the output register.
//   Clear and seed transactions give no output; the unit stays idle for them.
//   Reset empties the history and sets the window to 5; no clearing pass.
//   If the receiver stalls, the result holds in the output register; one
//   further sample may be taken, and its result waits until the register
//   is free, with s_tready low meanwhile.
module pen_moving_average_unit
    import pma_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,   // x_pos[31:0], y_pos[63:32], pressure[79:64]
    input  logic [1:0]        s_tuser,   // operation[1:0]
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // avg_x[31:0], avg_y[63:32], avg_pressure[79:64]
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [WIN_W-1:0]  cfg_data
);

    state_t              state_reg, state_next;
    logic [WIN_W-1:0]    window_reg, window_next;
    logic [SLOT_W-1:0]   write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CNT_W-1:0]    iss_cnt_reg, iss_cnt_next;
    logic [SLOT_W-1:0]   rd_addr_reg, rd_addr_next;
    logic                rd_valid_reg, rd_valid_next;
    logic [SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic [PSUM_W-1:0]   sum_p_reg, sum_p_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                accept;
    logic                issuing;
    logic                sum_done;
    logic                div_start;
    logic                div_done;
    logic                out_free;
    logic                out_load;
    logic                ram_we;
    logic [DATA_W-1:0]   ram_rd_data;
    logic [CNT_W:0]      fill_inc;
    logic [CNT_W:0]      win_ext;
    logic [CNT_W-1:0]    n_new;
    logic [SLOT_W-1:0]   slot_inc;
    logic                done_x, done_y, done_p;
    logic [DIV_W-1:0]    quot_x, quot_y, quot_p;

    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign sum_done  = (iss_cnt_reg == n_reg) && !rd_valid_reg;
    assign div_done  = done_x && done_y && done_p;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign fill_inc = {1'b0, fill_reg} + 1'b1;
    assign win_ext  = (CNT_W + 1)'(window_reg);
    assign n_new    = (fill_inc > win_ext) ? win_ext[CNT_W-1:0] : fill_inc[CNT_W-1:0];
    assign slot_inc = (write_slot_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0
                                                                  : write_slot_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && (s_tuser == OP_PROCESS))
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                if (sum_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        s_tready  = 1'b0;
        issuing   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                ram_we   = s_tvalid && ((s_tuser == OP_PROCESS) || (s_tuser == OP_SEED));
            end
            ST_SUM:
            begin
                issuing   = (iss_cnt_reg != n_reg);
                div_start = sum_done;
            end
            ST_DIV:
            begin
            end
            ST_OUT:
            begin
                out_load = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // datapath and bookkeeping
    always_comb
    begin
        window_next     = window_reg;
        write_slot_next = write_slot_reg;
        fill_next       = fill_reg;
        n_next          = n_reg;
        iss_cnt_next    = iss_cnt_reg;
        rd_addr_next    = rd_addr_reg;
        rd_valid_next   = issuing;
        sum_x_next      = sum_x_reg;
        sum_y_next      = sum_y_reg;
        sum_p_next      = sum_p_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;

        if (cfg_valid)
        begin
            if (cfg_data < WIN_W'(WINDOW_LOW))
            begin
                window_next = WIN_W'(WINDOW_LOW);
            end
            else if (cfg_data > WIN_W'(WINDOW_HIGH))
            begin
                window_next = WIN_W'(WINDOW_HIGH);
            end
            else
            begin
                window_next = cfg_data;
            end
        end

        if (accept)
        begin
            case (s_tuser)
                OP_PROCESS:
                begin
                    write_slot_next = slot_inc;
                    fill_next       = n_new;
                    n_next          = n_new;
                    iss_cnt_next    = '0;
                    rd_addr_next    = write_slot_reg;
                    sum_x_next      = '0;
                    sum_y_next      = '0;
                    sum_p_next      = '0;
                end
                OP_CLEAR:
                begin
                    fill_next = '0;
                end
                OP_SEED:
                begin
                    write_slot_next = slot_inc;
                    fill_next       = CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end

        // newest first, walking back round the ring
        if (issuing)
        begin
            iss_cnt_next = iss_cnt_reg + 1'b1;
            rd_addr_next = (rd_addr_reg == '0) ? SLOT_W'(MAX_WINDOW - 1) : rd_addr_reg - 1'b1;
        end

        if (rd_valid_reg)
        begin
            sum_x_next = sum_x_reg + {{(SUM_W - POS_W){ram_rd_data[X_LSB+POS_W-1]}},
                                      ram_rd_data[X_LSB +: POS_W]};
            sum_y_next = sum_y_reg + {{(SUM_W - POS_W){ram_rd_data[Y_LSB+POS_W-1]}},
                                      ram_rd_data[Y_LSB +: POS_W]};
            sum_p_next = sum_p_reg + PSUM_W'(ram_rd_data[P_LSB +: PRES_W]);
        end

        if (out_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {quot_p[PRES_W-1:0], quot_y[POS_W-1:0], quot_x[POS_W-1:0]};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_reg     <= WIN_W'(WINDOW_RESET);
            write_slot_reg <= '0;
            fill_reg       <= '0;
            n_reg          <= '0;
            iss_cnt_reg    <= '0;
            rd_addr_reg    <= '0;
            rd_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            write_slot_reg <= write_slot_next;
            fill_reg       <= fill_next;
            n_reg          <= n_next;
            iss_cnt_reg    <= iss_cnt_next;
            rd_addr_reg    <= rd_addr_next;
            rd_valid_reg   <= rd_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_x_reg   <= sum_x_next;
        sum_y_reg   <= sum_y_next;
        sum_p_reg   <= sum_p_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    pma_ram #(
        .DEPTH (MAX_WINDOW),
        .WIDTH (DATA_W)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (write_slot_reg),
        .wr_data (s_tdata),
        .rd_en   (issuing),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_rd_data)
    );

    pma_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .is_signed (1'b1),
        .dividend  (sum_x_reg),
        .divisor   (n_reg),
        .done      (done_x),
        .quotient  (quot_x)
    );

    pma_div u_div_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .is_signed (1'b1),
        .dividend  (sum_y_reg),
        .divisor   (n_reg),
        .done      (done_y),
        .quotient  (quot_y)
    );

    pma_div u_div_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .is_signed (1'b0),
        .dividend  (SUM_W'(sum_p_reg)),
        .divisor   (n_reg),
        .done      (done_p),
        .quotient  (quot_p)
    );

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        write_slot_reg < SLOT_W'(MAX_WINDOW))
        else $error("write slot beyond history depth");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(WINDOW_HIGH))
        else $error("fill count beyond window limit");
    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SUM) |-> ((iss_cnt_reg <= n_reg) && (n_reg != '0)))
        else $error("history reads overran the count");
    a_process_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == OP_PROCESS)) |=> ((state_reg == ST_SUM) && (fill_reg == n_reg)))
        else $error("process transaction did not start summing");
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside output state");
`endif

endmodule

// File: bench/tb_pen_moving_average_unit.sv
// Self-checking bench for the pen moving average unit: boxcar predictor against the streams.
`timescale 1ns / 1ps

module tb_pen_moving_average_unit
    import pma_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;    // worst-case latency plus margin
    localparam int PHASE_ITEMS    = 250;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [PRES_W-1:0]       p;
    } pen_point_t;

    typedef struct {
        logic [1:0] op;
        pen_point_t pt;
        bit         typed;
        pen_point_t want;
    } stim_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata   = '0;
    logic [1:0]        s_tuser   = OP_PROCESS;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [WIN_W-1:0]  cfg_data  = '0;

    // Predictor state
    pen_point_t hist [MAX_WINDOW];
    int         next_slot = 0;
    int         stored    = 0;
    int         win_len   = WINDOW_RESET;

    pen_point_t pending_avgs [$];
    stim_row_t  directed_rows [$];
    int         mismatches   = 0;
    int         tx_idle_pct  = 0;
    int         rx_idle_pct  = 0;
    int         quiet_cycles = 0;

    pen_moving_average_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Updates the history for one transaction; returns 1 with the mean when one is due.
    function automatic bit smooth_sample(input logic [1:0] op, input pen_point_t pt,
                                         output pen_point_t avg);
        longint sum_x;
        longint sum_y;
        longint sum_p;
        int     n;
        int     slot;
        avg = '0;
        if (op == OP_CLEAR)
        begin
            stored = 0;
            return 1'b0;
        end
        if (op != OP_PROCESS && op != OP_SEED)
            return 1'b0;
        hist[next_slot] = pt;
        next_slot = (next_slot + 1) % MAX_WINDOW;
        if (op == OP_SEED)
        begin
            stored = 1;
            return 1'b0;
        end
        // a lowered window simply drops the oldest entries here
        n = (stored + 1 > win_len) ? win_len : stored + 1;
        stored = n;
        sum_x = 0;
        sum_y = 0;
        sum_p = 0;
        for (int i = 0; i < n; i++)
        begin
            slot = (next_slot + MAX_WINDOW - 1 - i) % MAX_WINDOW;
            sum_x += longint'($signed(hist[slot].x));
            sum_y += longint'($signed(hist[slot].y));
            sum_p += longint'(hist[slot].p);
        end
        // signed division truncates toward zero
        avg.x = POS_W'(sum_x / n);
        avg.y = POS_W'(sum_y / n);
        avg.p = PRES_W'(sum_p / n);
        return 1'b1;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_row(input logic [1:0] op, input logic [31:0] x, input logic [31:0] y,
                           input logic [15:0] p, input bit typed, input logic [31:0] wx,
                           input logic [31:0] wy, input logic [15:0] wp);
        stim_row_t r;
        r.op    = op;
        r.pt    = {x, y, p};
        r.typed = typed;
        r.want  = {wx, wy, wp};
        directed_rows.insert(directed_rows.size(), r);
    endtask

    task automatic send_sample(input logic [1:0] op, input pen_point_t pt, input bit typed,
                               input pen_point_t want);
        pen_point_t avg;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {pt.p, pt.y, pt.x};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (smooth_sample(op, pt, avg))
            pending_avgs.insert(pending_avgs.size(), typed ? want : avg);
    endtask

    // Lets every outstanding mean arrive, then covers any clear or seed still in flight.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_avgs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_window(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[WIN_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        win_len = (value < WINDOW_LOW) ? WINDOW_LOW : (value > WINDOW_HIGH) ? WINDOW_HIGH : value;
    endtask

    task automatic run_phase(input int items);
        int         sent;
        int         roll;
        logic [1:0] op;
        logic [31:0] w;
        pen_point_t pt;
        sent = 0;
        while (sent < items)
        begin
            roll = $urandom_range(99);
            op = (roll < 3) ? OP_CLEAR : (roll < 6) ? OP_SEED : (roll < 8) ? OP_UNUSED
                                                                              : OP_PROCESS;
            pt.x = pick_word();
            pt.y = pick_word();
            w    = pick_word();
            pt.p = w[PRES_W-1:0];
            send_sample(op, pt, 1'b0, '0);
            if (op != OP_UNUSED)
                sent++;
        end
    endtask

    always @(posedge clk)
    begin : check_avgs
        pen_point_t got;
        pen_point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x = m_tdata[X_LSB +: POS_W];
            got.y = m_tdata[Y_LSB +: POS_W];
            got.p = m_tdata[P_LSB +: PRES_W];
            if (pending_avgs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected mean: x=%h y=%h p=%h", got.x, got.y, got.p);
            end
            else
            begin
                want = pending_avgs.pop_front();
                if (got.x !== want.x || got.y !== want.y || got.p !== want.p)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mean mismatch: expected x=%h y=%h p=%h, got x=%h y=%h p=%h",
                                 want.x, want.y, want.p, got.x, got.y, got.p);
                end
            end
        end
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_pen_moving_average_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        int windows [8];
        windows = '{31, 0, 20, 2, 1, 21, 0, 13};
        windows[6] = $urandom_range(31);

        // Window 5 from reset throughout the table
        add_row(OP_PROCESS, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        add_row(OP_PROCESS, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF,
                1, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF);
        add_row(OP_PROCESS, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000, 0, '0, '0, '0);
        add_row(OP_UNUSED,  32'h0000_0001, 32'h0000_0001, 16'h0001, 0, '0, '0, '0);
        add_row(OP_CLEAR,   32'h1234_5678, 32'h9ABC_DEF0, 16'h5555, 0, '0, '0, '0);
        add_row(OP_PROCESS, 32'hFFFF_FFFD, 32'h0000_0003, 16'h0001,
                1, 32'hFFFF_FFFD, 32'h0000_0003, 16'h0001);
        add_row(OP_PROCESS, 32'h0000_0000, 32'h0000_0000, 16'h0000, 0, '0, '0, '0);
        add_row(OP_SEED,    32'h0000_0064, 32'hFFFF_FF9C, 16'h000A, 0, '0, '0, '0);
        add_row(OP_PROCESS, 32'h0000_0065, 32'hFFFF_FF9B, 16'h000B, 0, '0, '0, '0);
        repeat (5)
            add_row(OP_PROCESS, 32'h8000_0000, 32'h8000_0000, 16'hFFFF, 0, '0, '0, '0);
        // history now full of minima, the oldest dropped
        add_row(OP_PROCESS, 32'h8000_0000, 32'h8000_0000, 16'hFFFF,
                1, 32'h8000_0000, 32'h8000_0000, 16'hFFFF);
        add_row(OP_SEED,    32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 0, '0, '0, '0);
        add_row(OP_PROCESS, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000,
                1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
        add_row(OP_CLEAR,   32'h0000_0000, 32'h0000_0000, 16'h0000, 0, '0, '0, '0);
        add_row(OP_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, '0, '0, '0);
        add_row(OP_PROCESS, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0002,
                1, 32'h0000_0001, 32'hFFFF_FFFF, 16'h0002);
        add_row(OP_UNUSED,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 0, '0, '0, '0);
        add_row(OP_PROCESS, 32'hFFFF_FFFF, 32'h0000_0001, 16'h0001, 0, '0, '0, '0);

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].op, directed_rows[i].pt, directed_rows[i].typed,
                        directed_rows[i].want);

        foreach (windows[i])
        begin
            wait_idle();
            write_window(windows[i]);
            tx_idle_pct = (i < 3) ? 22 : (i < 6) ? 88 : 0;
            rx_idle_pct = (i < 3) ? 88 : (i < 6) ? 22 : 0;
            run_phase(PHASE_ITEMS / 2);
            // hold the source until the output side has fully drained
            if (i == 1)
                wait_idle();
            run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        wait_idle();
        if (mismatches == 0 && pending_avgs.size() == 0)
            $display("tb_pen_moving_average_unit: PASS");
        else
            $display("tb_pen_moving_average_unit: FAIL");
        $finish;
    end

endmodule

// File: pen_moving_average_unit.f
hdl/pma_pkg.sv
hdl/pma_ram.sv
hdl/pma_div.sv
hdl/pen_moving_average_unit.sv
bench/tb_pen_moving_average_unit.sv
